FILE: hdl/casc_pkg.sv
// Shared types, codes and calendar helpers for the alarm setting controller.
package casc_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL       = 3'd0,
    MODE_HOUR         = 3'd1,
    MODE_MINUTE       = 3'd2,
    MODE_DAY          = 3'd3,
    MODE_MONTH        = 3'd4,
    MODE_YEAR         = 3'd5,
    MODE_ALARM_HOUR   = 3'd6,
    MODE_ALARM_MINUTE = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE          = 3'd0,
    CMD_RING          = 3'd1,
    CMD_DISMISS       = 3'd2,
    CMD_RING_DISMISS  = 3'd3,
    CMD_COMMIT_CLOCK  = 3'd4,
    CMD_COMMIT_ALARM  = 3'd5,
    CMD_ALARM_TOGGLE  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    REDRAW_NONE    = 2'd0,
    REDRAW_PARTIAL = 2'd1,
    REDRAW_FULL    = 2'd2
  } redraw_t;

  typedef struct packed {
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [4:0]  now_day;
    logic [3:0]  now_month;
    logic [11:0] now_year;
    logic        alarm_fired;
    logic        set_short;
    logic        set_long;
    logic        plus_short;
    logic        plus_long;
    logic        minus_short;
    logic        minus_long;
  } casc_in_t;

  typedef struct packed {
    logic [2:0]  mode_now;
    logic        ringing_now;
    logic [4:0]  out_edit_hour;
    logic [5:0]  out_edit_minute;
    logic [4:0]  out_edit_day;
    logic [3:0]  out_edit_month;
    logic [11:0] out_edit_year;
    logic [4:0]  out_alarm_hour;
    logic [5:0]  out_alarm_minute;
    logic        out_alarm_on;
    logic [1:0]  redraw_kind;
    logic [2:0]  command_code;
  } casc_out_t;

  typedef struct packed {
    mode_t       mode;
    logic        ringing;
    logic [4:0]  edit_hour;
    logic [5:0]  edit_minute;
    logic [4:0]  edit_day;
    logic [3:0]  edit_month;
    logic [11:0] edit_year;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic        alarm_on;
    logic [7:0]  last_minute;
    logic [3:0]  partial_count;
    logic        force_full;
  } casc_state_t;

  localparam logic [7:0]  LAST_MIN_NONE = 8'd255;
  localparam logic [3:0]  INTERVAL_RST  = 4'd3;
  localparam logic [11:0] HOUR_MAX      = 12'd23;
  localparam logic [11:0] MINUTE_MAX    = 12'd59;
  localparam logic [11:0] MONTH_MAX     = 12'd12;
  localparam logic [11:0] YEAR_MIN      = 12'd2000;
  localparam logic [11:0] YEAR_MAX      = 12'd2099;
  localparam logic [11:0] ZERO_LO       = 12'd0;
  localparam logic [11:0] ONE_LO        = 12'd1;

  localparam casc_state_t STATE_RST = '{
    mode:          MODE_NORMAL,
    ringing:       1'b0,
    edit_hour:     5'd0,
    edit_minute:   6'd0,
    edit_day:      5'd1,
    edit_month:    4'd1,
    edit_year:     12'd2026,
    alarm_hour:    5'd7,
    alarm_minute:  6'd0,
    alarm_on:      1'b0,
    last_minute:   LAST_MIN_NONE,
    partial_count: 4'd0,
    force_full:    1'b1
  };

  // y/100 via y/4 then reciprocal of 25 (exact for y4 < 1024)
  function automatic logic is_leap(input logic [11:0] y);
    logic [9:0]  y4;
    logic [20:0] prod;
    logic [5:0]  q;
    logic [9:0]  rem;
    logic        div4;
    logic        div100;
    y4     = y[11:2];
    prod   = 21'(y4) * 21'd1311;
    q      = prod[20:15];
    rem    = y4 - 10'(10'(q) * 10'd25);
    div4   = (y[1:0] == 2'd0);
    div100 = div4 && (rem == 10'd0);
    return div4 && (!div100 || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
    logic [4:0] len;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = is_leap(y) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [4:0] clamp_day(input logic [4:0] d, input logic [3:0] m,
                                           input logic [11:0] y);
    logic [4:0] md;
    md = month_len(m, y);
    return (d > md) ? md : d;
  endfunction

  function automatic logic [11:0] inc_wrap(input logic [11:0] v, input logic [11:0] lo,
                                           input logic [11:0] hi);
    logic [12:0] s;
    s = {1'b0, v} + 13'd1;
    return (s > {1'b0, hi}) ? lo : s[11:0];
  endfunction

  function automatic logic [11:0] dec_wrap(input logic [11:0] v, input logic [11:0] lo,
                                           input logic [11:0] hi);
    return (v <= lo) ? hi : v - 12'd1;
  endfunction

endpackage

FILE: hdl/casc_step.sv
// Next-state and result logic for one poll beat.
module casc_step (
  input  casc_pkg::casc_state_t st_cur,
  input  casc_pkg::casc_in_t    item,
  input  logic [3:0]            interval,
  output casc_pkg::casc_state_t st_nxt,
  output casc_pkg::casc_out_t   res
);
  import casc_pkg::*;

  always_comb begin
    casc_state_t s;
    cmd_t        cmd;
    redraw_t     redraw;
    logic [4:0]  md;
    logic [3:0]  lim;
    s      = st_cur;
    cmd    = CMD_NONE;
    redraw = REDRAW_NONE;
    md     = month_len(st_cur.edit_month, st_cur.edit_year);
    lim    = (interval == 4'd0) ? 4'd0 : interval - 4'd1;

    if (!s.ringing && item.alarm_fired) begin
      s.ringing = 1'b1;
      cmd       = CMD_RING;
    end

    if (s.ringing) begin
      if (item.set_short) begin
        s.ringing     = 1'b0;
        s.last_minute = LAST_MIN_NONE;
        s.force_full  = 1'b1;
        cmd           = (cmd == CMD_RING) ? CMD_RING_DISMISS : CMD_DISMISS;
      end
    end else begin
      unique case (s.mode)
        MODE_NORMAL: begin
          if ({2'b00, item.now_minute} != s.last_minute) begin
            if (s.force_full || s.partial_count >= lim) begin
              redraw          = REDRAW_FULL;
              s.partial_count = 4'd0;
              s.force_full    = 1'b0;
            end else begin
              redraw          = REDRAW_PARTIAL;
              s.partial_count = s.partial_count + 4'd1;
            end
            s.last_minute = {2'b00, item.now_minute};
          end
          priority if (item.set_long) begin
            s.edit_hour   = item.now_hour;
            s.edit_minute = item.now_minute;
            s.edit_day    = item.now_day;
            s.edit_month  = item.now_month;
            s.edit_year   = item.now_year;
            s.mode        = MODE_HOUR;
          end else if (item.plus_long) begin
            s.mode = MODE_ALARM_HOUR;
          end else if (item.minus_long) begin
            s.alarm_on = ~s.alarm_on;
            cmd        = CMD_ALARM_TOGGLE;
          end else begin
            s.mode = MODE_NORMAL;
          end
        end
        MODE_HOUR: begin
          if (item.plus_short)
            s.edit_hour = 5'(inc_wrap(12'(s.edit_hour), ZERO_LO, HOUR_MAX));
          if (item.minus_short)
            s.edit_hour = 5'(dec_wrap(12'(s.edit_hour), ZERO_LO, HOUR_MAX));
          if (item.set_short) s.mode = MODE_MINUTE;
        end
        MODE_MINUTE: begin
          if (item.plus_short)
            s.edit_minute = 6'(inc_wrap(12'(s.edit_minute), ZERO_LO, MINUTE_MAX));
          if (item.minus_short)
            s.edit_minute = 6'(dec_wrap(12'(s.edit_minute), ZERO_LO, MINUTE_MAX));
          if (item.set_short) s.mode = MODE_DAY;
        end
        MODE_DAY: begin
          if (item.plus_short)
            s.edit_day = 5'(inc_wrap(12'(s.edit_day), ONE_LO, 12'(md)));
          if (item.minus_short)
            s.edit_day = 5'(dec_wrap(12'(s.edit_day), ONE_LO, 12'(md)));
          if (item.set_short) s.mode = MODE_MONTH;
        end
        MODE_MONTH: begin
          if (item.plus_short) begin
            s.edit_month = 4'(inc_wrap(12'(s.edit_month), ONE_LO, MONTH_MAX));
            s.edit_day   = clamp_day(s.edit_day, s.edit_month, s.edit_year);
          end
          if (item.minus_short) begin
            s.edit_month = 4'(dec_wrap(12'(s.edit_month), ONE_LO, MONTH_MAX));
            s.edit_day   = clamp_day(s.edit_day, s.edit_month, s.edit_year);
          end
          if (item.set_short) s.mode = MODE_YEAR;
        end
        MODE_YEAR: begin
          if (item.plus_short) begin
            s.edit_year = inc_wrap(s.edit_year, YEAR_MIN, YEAR_MAX);
            s.edit_day  = clamp_day(s.edit_day, s.edit_month, s.edit_year);
          end
          if (item.minus_short) begin
            s.edit_year = dec_wrap(s.edit_year, YEAR_MIN, YEAR_MAX);
            s.edit_day  = clamp_day(s.edit_day, s.edit_month, s.edit_year);
          end
          if (item.set_short) begin
            s.mode        = MODE_NORMAL;
            s.last_minute = LAST_MIN_NONE;
            s.force_full  = 1'b1;
            cmd           = CMD_COMMIT_CLOCK;
          end
        end
        MODE_ALARM_HOUR: begin
          if (item.plus_short)
            s.alarm_hour = 5'(inc_wrap(12'(s.alarm_hour), ZERO_LO, HOUR_MAX));
          if (item.minus_short)
            s.alarm_hour = 5'(dec_wrap(12'(s.alarm_hour), ZERO_LO, HOUR_MAX));
          if (item.set_short) s.mode = MODE_ALARM_MINUTE;
        end
        MODE_ALARM_MINUTE: begin
          if (item.plus_short)
            s.alarm_minute = 6'(inc_wrap(12'(s.alarm_minute), ZERO_LO, MINUTE_MAX));
          if (item.minus_short)
            s.alarm_minute = 6'(dec_wrap(12'(s.alarm_minute), ZERO_LO, MINUTE_MAX));
          if (item.set_short) begin
            s.mode        = MODE_NORMAL;
            s.last_minute = LAST_MIN_NONE;
            s.force_full  = 1'b1;
            cmd           = CMD_COMMIT_ALARM;
          end
        end
      endcase
    end

    st_nxt = s;

    res.mode_now         = s.mode;
    res.ringing_now      = s.ringing;
    res.out_edit_hour    = s.edit_hour;
    res.out_edit_minute  = s.edit_minute;
    res.out_edit_day     = s.edit_day;
    res.out_edit_month   = s.edit_month;
    res.out_edit_year    = s.edit_year;
    res.out_alarm_hour   = s.alarm_hour;
    res.out_alarm_minute = s.alarm_minute;
    res.out_alarm_on     = s.alarm_on;
    res.redraw_kind      = redraw;
    res.command_code     = cmd;
  end

endmodule

FILE: hdl/clock_alarm_setting_controller_unit.sv
// Top level of the alarm clock setting controller: beat registers and state.
// A result beat passes through the input beat register and then the result register; out_stall can hold it.
// Throughput: one poll beat per cycle while out_stall is low, set by the single pass through casc_step.
// Reset (rst_n low, synchronous): mode normal, not ringing, alarm 07:00 off,
// edit date 2026-01-01 00:00, forced full redraw pending, interval 3,
// both beat registers empty.
module clock_alarm_setting_controller_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  casc_pkg::casc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output casc_pkg::casc_out_t out_data,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata
);
  import casc_pkg::*;

  // Input beat register, then one pass of logic into the result register.
  logic        in_valid_r;
  casc_in_t    in_data_r;
  logic        out_valid_r;
  casc_out_t   out_data_r;

  // Controller state and the refresh interval register.
  casc_state_t state_r;
  casc_state_t state_nxt;
  casc_out_t   res_nxt;
  logic [3:0]  interval_r;

  logic out_free;
  logic advance;
  logic in_take;

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // A held beat moves through the logic whenever the result slot is free.
  assign advance  = in_valid_r && out_free;
  // Stall only when the input register is full and cannot drain.
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  casc_step u_step (
    .st_cur   (state_r),
    .item     (in_data_r),
    .interval (interval_r),
    .st_nxt   (state_nxt),
    .res      (res_nxt)
  );

  // Control: beat valids, state and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RST;
      interval_r  <= INTERVAL_RST;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // Redraw decisions are only made while not ringing.
  a_redraw_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.redraw_kind != REDRAW_NONE) |-> !out_data_r.ringing_now)
    else $error("redraw reported while ringing");

  // A dismiss always leaves the alarm silent.
  a_dismiss_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((out_data_r.command_code == CMD_DISMISS) ||
                    (out_data_r.command_code == CMD_RING_DISMISS))
    |-> !out_data_r.ringing_now)
    else $error("dismiss reported with ringing still set");

  // A ring start alone leaves the alarm ringing.
  a_ring_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.command_code == CMD_RING) |-> out_data_r.ringing_now)
    else $error("ring start without ringing");

  // Commits return to normal mode.
  a_commit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((out_data_r.command_code == CMD_COMMIT_CLOCK) ||
                    (out_data_r.command_code == CMD_COMMIT_ALARM))
    |-> (out_data_r.mode_now == MODE_NORMAL))
    else $error("commit without return to normal mode");

  // A full redraw restarts the partial count.
  a_full_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res_nxt.redraw_kind == REDRAW_FULL) |=> (state_r.partial_count == 4'd0))
    else $error("partial count not cleared by full redraw");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the alarm clock setting controller.
module tb_top;
  import casc_pkg::*;

  // Button event masks for directed polls: {fired, set_s, set_l, plus_s, plus_l, minus_s, minus_l}
  localparam logic [6:0] BTN_NONE    = 7'b0000000;
  localparam logic [6:0] BTN_FIRED   = 7'b1000000;
  localparam logic [6:0] BTN_SET_S   = 7'b0100000;
  localparam logic [6:0] BTN_SET_L   = 7'b0010000;
  localparam logic [6:0] BTN_PLUS_S  = 7'b0001000;
  localparam logic [6:0] BTN_PLUS_L  = 7'b0000100;
  localparam logic [6:0] BTN_MINUS_S = 7'b0000010;
  localparam logic [6:0] BTN_MINUS_L = 7'b0000001;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAUSE = 6;   // settling pause once the block looks quiet
  localparam int PHASE_POLLS = 220;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  casc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  casc_out_t out_data;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;

  clock_alarm_setting_controller_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Polls waiting to be driven, and the status beats they must produce, oldest first.
  casc_in_t  pending_polls[$];
  casc_out_t status_due[$];

  int idle_pct = 0;    // chance the sender leaves a cycle empty
  int stall_pct = 0;   // chance the receiver stalls a cycle
  int mismatches = 0;
  int cycles = 0;

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller state and its refresh interval register.
  // ---------------------------------------------------------------------------
  logic [3:0]  m_interval = INTERVAL_RST;
  mode_t       m_mode = MODE_NORMAL;
  logic        m_ring = 1'b0;
  logic [4:0]  m_ed_hour = 5'd0;
  logic [5:0]  m_ed_min = 6'd0;
  logic [4:0]  m_ed_day = 5'd1;
  logic [3:0]  m_ed_mon = 4'd1;
  logic [11:0] m_ed_year = 12'd2026;
  logic [4:0]  m_al_hour = 5'd7;
  logic [5:0]  m_al_min = 6'd0;
  logic        m_al_on = 1'b0;
  logic [7:0]  m_last_min = LAST_MIN_NONE;
  logic [3:0]  m_partials = 4'd0;
  logic        m_force = 1'b1;

  function automatic bit leap_year(int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  // Anything that is not a known short month counts as 31 days, bad months included.
  function automatic int unsigned days_in_month(int unsigned mo, int unsigned y);
    case (mo)
      4, 6, 9, 11: return 30;
      2:           return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic int unsigned step_up(int unsigned v, int unsigned lo, int unsigned hi);
    return (v + 1 > hi) ? lo : v + 1;
  endfunction

  // Values at or below the low bound (day zero, for one) wrap to the top.
  function automatic int unsigned step_down(int unsigned v, int unsigned lo, int unsigned hi);
    return (v <= lo) ? hi : v - 1;
  endfunction

  function automatic void clamp_edit_day();
    int unsigned md;
    md = days_in_month(m_ed_mon, m_ed_year);
    if (m_ed_day > md) m_ed_day = 5'(md);
  endfunction

  // Advance the shadow state by one poll and return the status beat it yields.
  function automatic casc_out_t predict_status(casc_in_t p);
    casc_out_t   r;
    redraw_t     redraw;
    cmd_t        cmd;
    int unsigned lim;
    int unsigned md;
    redraw = REDRAW_NONE;
    cmd = CMD_NONE;
    // A fired flag is only news while not already ringing.
    if (!m_ring && p.alarm_fired) begin
      m_ring = 1'b1;
      cmd = CMD_RING;
    end
    if (m_ring) begin
      // While ringing only a short set press matters: it dismisses.
      if (p.set_short) begin
        m_ring = 1'b0;
        m_last_min = LAST_MIN_NONE;
        m_force = 1'b1;
        cmd = (cmd == CMD_RING) ? CMD_RING_DISMISS : CMD_DISMISS;
      end
    end else begin
      // plus, then minus, then set within each edit mode
      case (m_mode)
        MODE_NORMAL: begin
          if (8'(p.now_minute) != m_last_min) begin
            lim = (m_interval == 0) ? 0 : m_interval - 1;
            if (m_force || m_partials >= lim) begin
              redraw = REDRAW_FULL;
              m_partials = 4'd0;
              m_force = 1'b0;
            end else begin
              redraw = REDRAW_PARTIAL;
              m_partials = m_partials + 4'd1;
            end
            m_last_min = 8'(p.now_minute);
          end
          // long set beats long plus beats long minus
          if (p.set_long) begin
            m_ed_hour = p.now_hour;
            m_ed_min = p.now_minute;
            m_ed_day = p.now_day;
            m_ed_mon = p.now_month;
            m_ed_year = p.now_year;
            m_mode = MODE_HOUR;
          end else if (p.plus_long) begin
            m_mode = MODE_ALARM_HOUR;
          end else if (p.minus_long) begin
            m_al_on = !m_al_on;
            cmd = CMD_ALARM_TOGGLE;
          end
        end
        MODE_HOUR: begin
          if (p.plus_short) m_ed_hour = 5'(step_up(m_ed_hour, 0, 23));
          if (p.minus_short) m_ed_hour = 5'(step_down(m_ed_hour, 0, 23));
          if (p.set_short) m_mode = MODE_MINUTE;
        end
        MODE_MINUTE: begin
          if (p.plus_short) m_ed_min = 6'(step_up(m_ed_min, 0, 59));
          if (p.minus_short) m_ed_min = 6'(step_down(m_ed_min, 0, 59));
          if (p.set_short) m_mode = MODE_DAY;
        end
        MODE_DAY: begin
          md = days_in_month(m_ed_mon, m_ed_year);
          if (p.plus_short) m_ed_day = 5'(step_up(m_ed_day, 1, md));
          if (p.minus_short) m_ed_day = 5'(step_down(m_ed_day, 1, md));
          if (p.set_short) m_mode = MODE_MONTH;
        end
        MODE_MONTH: begin
          if (p.plus_short) begin
            m_ed_mon = 4'(step_up(m_ed_mon, 1, 12));
            clamp_edit_day();
          end
          if (p.minus_short) begin
            m_ed_mon = 4'(step_down(m_ed_mon, 1, 12));
            clamp_edit_day();
          end
          if (p.set_short) m_mode = MODE_YEAR;
        end
        MODE_YEAR: begin
          if (p.plus_short) begin
            m_ed_year = 12'(step_up(m_ed_year, 2000, 2099));
            clamp_edit_day();
          end
          if (p.minus_short) begin
            m_ed_year = 12'(step_down(m_ed_year, 2000, 2099));
            clamp_edit_day();
          end
          if (p.set_short) begin
            m_mode = MODE_NORMAL;
            m_last_min = LAST_MIN_NONE;
            m_force = 1'b1;
            cmd = CMD_COMMIT_CLOCK;
          end
        end
        MODE_ALARM_HOUR: begin
          if (p.plus_short) m_al_hour = 5'(step_up(m_al_hour, 0, 23));
          if (p.minus_short) m_al_hour = 5'(step_down(m_al_hour, 0, 23));
          if (p.set_short) m_mode = MODE_ALARM_MINUTE;
        end
        default: begin
          if (p.plus_short) m_al_min = 6'(step_up(m_al_min, 0, 59));
          if (p.minus_short) m_al_min = 6'(step_down(m_al_min, 0, 59));
          if (p.set_short) begin
            m_mode = MODE_NORMAL;
            m_last_min = LAST_MIN_NONE;
            m_force = 1'b1;
            cmd = CMD_COMMIT_ALARM;
          end
        end
      endcase
    end
    r.mode_now = m_mode;
    r.ringing_now = m_ring;
    r.out_edit_hour = m_ed_hour;
    r.out_edit_minute = m_ed_min;
    r.out_edit_day = m_ed_day;
    r.out_edit_month = m_ed_mon;
    r.out_edit_year = m_ed_year;
    r.out_alarm_hour = m_al_hour;
    r.out_alarm_minute = m_al_min;
    r.out_alarm_on = m_al_on;
    r.redraw_kind = redraw;
    r.command_code = cmd;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Poll generation. A wall clock ticks forward so minute changes look real;
  // a share of polls is raw noise to reach out-of-range edit values.
  // ---------------------------------------------------------------------------
  int unsigned w_hour = 0, w_min = 0, w_day = 1, w_mon = 1, w_year = 2024;

  function automatic casc_in_t make_poll(int unsigned h, int unsigned mi, int unsigned d,
                                         int unsigned mo, int unsigned y, logic [6:0] btn);
    return {5'(h), 6'(mi), 5'(d), 4'(mo), 12'(y), btn};
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic casc_in_t random_poll();
    casc_in_t    p;
    logic [63:0] raw;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 12) begin
      raw = {$urandom, $urandom};
      return raw[38:0];
    end
    if (roll < 17) begin
      // jump somewhere else on the calendar
      w_year = $urandom_range(2099, 2000);
      w_mon = $urandom_range(12, 1);
      w_day = $urandom_range(days_in_month(w_mon, w_year), 1);
      w_hour = $urandom_range(23);
      w_min = $urandom_range(59);
    end else if (chance(40)) begin
      w_min++;
      if (w_min > 59) begin
        w_min = 0;
        w_hour++;
      end
      if (w_hour > 23) begin
        w_hour = 0;
        w_day++;
      end
      if (w_day > days_in_month(w_mon, w_year)) begin
        w_day = 1;
        w_mon++;
      end
      if (w_mon > 12) begin
        w_mon = 1;
        w_year++;
      end
      if (w_year > 2099) w_year = 2000;
    end
    p = make_poll(w_hour, w_min, w_day, w_mon, w_year, BTN_NONE);
    p.alarm_fired = chance(4);
    p.set_short = chance(20);
    p.set_long = chance(6);
    p.plus_short = chance(35);
    p.plus_long = chance(5);
    p.minus_short = chance(30);
    p.minus_long = chance(5);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued polls, leaving random gaps per idle_pct.
  // A held beat stays put until it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) status_due.push_back(predict_status(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_polls.size() != 0 && !chance(idle_pct)) begin
          in_valid <= 1'b1;
          in_data <= pending_polls.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each taken status beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  casc_out_t want;

  task automatic check_field(string name, logic [11:0] exp_v, logic [11:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("status beat arrived with none predicted");
          mismatches++;
        end else begin
          want = status_due.pop_front();
          check_field("mode_now", want.mode_now, out_data.mode_now);
          check_field("ringing_now", want.ringing_now, out_data.ringing_now);
          check_field("out_edit_hour", want.out_edit_hour, out_data.out_edit_hour);
          check_field("out_edit_minute", want.out_edit_minute, out_data.out_edit_minute);
          check_field("out_edit_day", want.out_edit_day, out_data.out_edit_day);
          check_field("out_edit_month", want.out_edit_month, out_data.out_edit_month);
          check_field("out_edit_year", want.out_edit_year, out_data.out_edit_year);
          check_field("out_alarm_hour", want.out_alarm_hour, out_data.out_alarm_hour);
          check_field("out_alarm_minute", want.out_alarm_minute, out_data.out_alarm_minute);
          check_field("out_alarm_on", want.out_alarm_on, out_data.out_alarm_on);
          check_field("redraw_kind", want.redraw_kind, out_data.redraw_kind);
          check_field("command_code", want.command_code, out_data.command_code);
        end
      end
      out_stall <= chance(stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset, directed polls, then random phases with interval writes
  // only once the block has gone quiet.
  // ---------------------------------------------------------------------------
  // Quiet is confirmed again after the pause, since the driver may have
  // popped the last poll in the same cycle as the first look.
  task automatic wait_drained();
    do begin
      while (pending_polls.size() != 0 || in_valid || status_due.size() != 0)
        @(posedge clk);
      repeat (DRAIN_PAUSE) @(posedge clk);
    end while (pending_polls.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  task automatic write_interval(logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    m_interval = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (PHASE_POLLS) pending_polls.push_back(random_poll());
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk at the reset interval, no idling.
    // forced full redraw, then partial, then no minute change
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_NONE));
    pending_polls.push_back(make_poll(0, 1, 1, 1, 2000, BTN_NONE));
    pending_polls.push_back(make_poll(0, 1, 1, 1, 2000, BTN_NONE));
    pending_polls.push_back(make_poll(0, 59, 1, 1, 2000, BTN_MINUS_L));
    // all three long presses: set wins, edits load the field maxima
    pending_polls.push_back(make_poll(23, 59, 31, 12, 2099,
                                      BTN_SET_L | BTN_PLUS_L | BTN_MINUS_L));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_PLUS_S));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_MINUS_S));
    // plus, minus and set in one poll: net no change, then advance
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_PLUS_S | BTN_MINUS_S | BTN_SET_S));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_PLUS_S | BTN_SET_S));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_PLUS_S));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_MINUS_S | BTN_SET_S));
    // December -> January -> February of a non-leap year clamps day 31 to 28
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_PLUS_S));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_PLUS_S));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_SET_S));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_PLUS_S));
    pending_polls.push_back(make_poll(0, 0, 1, 1, 2000, BTN_MINUS_S | BTN_SET_S));
    // ring, fired again while ringing, dismiss, ring and dismiss together
    pending_polls.push_back(make_poll(12, 30, 15, 6, 2050, BTN_FIRED));
    pending_polls.push_back(make_poll(12, 30, 15, 6, 2050, BTN_FIRED | BTN_PLUS_L));
    pending_polls.push_back(make_poll(12, 31, 15, 6, 2050, BTN_SET_S));
    pending_polls.push_back(make_poll(12, 31, 15, 6, 2050, BTN_FIRED | BTN_SET_S));
    // alarm edit path down to a commit
    pending_polls.push_back(make_poll(12, 32, 15, 6, 2050, BTN_PLUS_L));
    pending_polls.push_back(make_poll(12, 32, 15, 6, 2050, BTN_MINUS_S | BTN_SET_S));
    pending_polls.push_back(make_poll(12, 32, 15, 6, 2050, BTN_MINUS_S | BTN_SET_S));
    pending_polls.push_back('1);
    pending_polls.push_back('0);
    wait_drained();

    write_interval(4'd1);
    run_random(0, 0);
    write_interval(4'd15);
    run_random(80, 0);
    write_interval(4'd0);   // behaves as one
    run_random(0, 80);
    write_interval(4'd7);
    run_random(36, 36);
    write_interval(4'($urandom_range(14, 2)));
    run_random(36, 80);

    if (mismatches == 0 && status_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
